[hw/rtl/fir_rh_pkg.sv]
// Shared constants and types for the ring-history FIR filter.
package fir_rh_pkg;

    // Field widths of the request and result payloads.
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int IDX_W       = 8;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 42;
    localparam int TAP_COUNT_W = 9;

    // Stream bus widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Default store depth and tap count after reset.
    localparam int                     MAX_TAPS_DEFAULT = 256;
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET  = 9'd65;

    // Request kinds carried on tuser.
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    // Per-cycle command from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clr;    // clear the accumulator for a new sum
        logic valid;  // operands on the data inputs are a tap to add
        logic last;   // this tap closes the sum
    } mac_op_t;

endpackage

[hw/rtl/fir_rh_mac.sv]
// Shared multiply-accumulate unit: one registered product and a wrapping accumulator.
module fir_rh_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fir_rh_pkg::mac_op_t                 op,
    input  logic signed [fir_rh_pkg::COEF_W-1:0]   coef,
    input  logic signed [fir_rh_pkg::SAMPLE_W-1:0] sample,
    output logic signed [fir_rh_pkg::ACC_W-1:0]    acc,
    output logic                                done
);
    import fir_rh_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic                     prod_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;

    // Product stage, then a sign-extended add that wraps at the accumulator width.
    assign prod_next = coef * sample;
    assign acc_next  = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Control flags of the product stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            prod_valid_reg <= op.valid;
            prod_last_reg  <= op.valid && op.last;
            done_reg       <= prod_valid_reg && prod_last_reg;
        end
    end

    // Product and accumulator data.
    always_ff @(posedge aclk) begin
        if (op.valid) begin
            prod_reg <= prod_next;
        end
        if (op.clr) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

[hw/rtl/fir_filter_ring_history_unit.sv]
// Top level of the direct-form FIR filter with a circular sample history.
//
// A request with tuser set writes one coefficient and the block stays ready. A
// request with tuser clear pushes a sample and yields one result: the sample is
// written to the history and the accumulator cleared, then the single shared
// multiply-accumulate unit visits one tap per cycle over n taps, n being the tap
// count capped at MAX_TAPS (none when n is zero), and the sum moves into the
// output register. s_axis_tready stays low until then, so back-to-back sample
// requests wait for the result, longer while the result side stalls. After
// reset both stores are swept to zero, during which no request is taken;
// tap-count writes are taken at any time. The result is the full 42-bit sum of
// sample times Q2.16 coefficient, coefficient 0 meeting the oldest sample.
module fir_filter_ring_history_unit #(
    parameter int MAX_TAPS = fir_rh_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Tap count register.
    input  logic                                 cfg_wr_en,
    input  logic [fir_rh_pkg::TAP_COUNT_W-1:0]   cfg_wr_data,
    // Requests: tdata = sample[15:0], coef_index[23:16], coef_value[41:24], zeros.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fir_rh_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tuser,  // mode
    // Results: tdata = filtered[41:0], zeros.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fir_rh_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import fir_rh_pkg::*;

    localparam int AW  = $clog2(MAX_TAPS);
    localparam int CW  = ($clog2(MAX_TAPS + 1) > TAP_COUNT_W) ?
                         $clog2(MAX_TAPS + 1) : TAP_COUNT_W;
    localparam int IW  = (AW > IDX_W) ? AW : IDX_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Stores.
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];

    // Control registers.
    logic [2:0]             state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [AW-1:0]          k_reg, k_next;
    logic [AW-1:0]          h_reg, h_next;
    logic [AW:0]            cnt_reg, cnt_next;
    logic [TAP_COUNT_W-1:0] tap_count_reg, tap_count_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   rd_valid_reg;
    logic                   rd_last_reg;

    // Payload registers.
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic signed [SAMPLE_W-1:0] hist_q_reg;
    logic signed [COEF_W-1:0]   coef_q_reg;
    logic [ACC_W-1:0]           m_data_reg;

    // Request fields.
    logic                       accept;
    logic                       in_mode;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [IDX_W-1:0]           in_idx;
    logic signed [COEF_W-1:0]   in_coef;
    logic                       idx_ok;

    // Address arithmetic and store ports.
    logic [AW-1:0]          wp_inc;
    logic [AW-1:0]          h_inc;
    logic [CW-1:0]          n_sat;
    logic [AW:0]            n_taps;
    logic [AW+1:0]          base_sum;
    logic [AW-1:0]          base;
    logic                   rd_en;
    logic                   rd_last;
    logic                   out_free;
    logic                   coef_we;
    logic [AW-1:0]          coef_waddr;
    logic signed [COEF_W-1:0]   coef_wdata;
    logic                   hist_we;
    logic [AW-1:0]          hist_waddr;
    logic signed [SAMPLE_W-1:0] hist_wdata;

    // MAC connection.
    mac_op_t                 mac_op;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;

    // Request decode.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_mode       = s_axis_tuser;
    assign in_sample     = signed'(s_axis_tdata[SAMPLE_W-1:0]);
    assign in_idx        = s_axis_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
    assign in_coef       = signed'(s_axis_tdata[SAMPLE_W+IDX_W+COEF_W-1:SAMPLE_W+IDX_W]);
    assign idx_ok        = ((IW+1)'(in_idx) < (IW+1)'(MAX_TAPS));

    // Circular pointer steps and the window start, reduced modulo the depth.
    assign wp_inc   = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : AW'(wp_reg + 1'b1);
    assign h_inc    = (h_reg == AW'(MAX_TAPS - 1)) ? '0 : AW'(h_reg + 1'b1);
    assign n_sat    = (CW'(tap_count_reg) > CW'(MAX_TAPS)) ? CW'(MAX_TAPS)
                                                           : CW'(tap_count_reg);
    assign n_taps   = (AW+1)'(n_sat);
    assign base_sum = (AW+2)'(wp_inc) + (AW+2)'(MAX_TAPS) - (AW+2)'(n_taps);
    assign base     = (base_sum >= (AW+2)'(MAX_TAPS)) ?
                      AW'(base_sum - (AW+2)'(MAX_TAPS)) : AW'(base_sum);

    // Tap issue.
    assign rd_en    = (state_reg == ST_RUN);
    assign rd_last  = (((AW+1)'(k_reg) + (AW+1)'(1)) == cnt_reg);
    assign out_free = !m_valid_reg || m_axis_tready;

    // Store write ports: the clearing sweep, coefficient writes and sample pushes.
    assign coef_we    = (state_reg == ST_CLEAR) ||
                        (accept && (in_mode == MODE_COEF) && idx_ok);
    assign coef_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : AW'(in_idx);
    assign coef_wdata = (state_reg == ST_CLEAR) ? '0 : in_coef;
    assign hist_we    = (state_reg == ST_CLEAR) || (state_reg == ST_LOAD);
    assign hist_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : wp_reg;
    assign hist_wdata = (state_reg == ST_CLEAR) ? '0 : smp_reg;

    // Stores with registered read data.
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (rd_en) begin
            coef_q_reg <= coef_mem[k_reg];
            hist_q_reg <= hist_mem[h_reg];
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        wp_next        = wp_reg;
        k_next         = k_reg;
        h_next         = h_reg;
        cnt_next       = cnt_reg;
        tap_count_next = cfg_wr_en ? cfg_wr_data : tap_count_reg;
        m_valid_next   = (m_valid_reg && m_axis_tready) ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = AW'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == AW'(MAX_TAPS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (in_mode == MODE_FILTER)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                wp_next  = wp_inc;
                k_next   = '0;
                h_next   = base;
                cnt_next = n_taps;
                state_next = (n_taps == '0) ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                k_next = AW'(k_reg + 1'b1);
                h_next = h_inc;
                if (rd_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wp_reg        <= '0;
            k_reg         <= '0;
            h_reg         <= '0;
            cnt_reg       <= '0;
            tap_count_reg <= TAP_COUNT_RESET;
            m_valid_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wp_reg        <= wp_next;
            k_reg         <= k_next;
            h_reg         <= h_next;
            cnt_reg       <= cnt_next;
            tap_count_reg <= tap_count_next;
            m_valid_reg   <= m_valid_next;
            rd_valid_reg  <= rd_en;
            rd_last_reg   <= rd_en && rd_last;
        end
    end

    // Sample capture and the result register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            smp_reg <= in_sample;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg <= mac_acc;
        end
    end

    // Shared multiply-accumulate unit.
    assign mac_op.clr   = (state_reg == ST_LOAD);
    assign mac_op.valid = rd_valid_reg;
    assign mac_op.last  = rd_last_reg;

    fir_rh_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .coef    (coef_q_reg),
        .sample  (hist_q_reg),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-ACC_W){1'b0}}, m_data_reg};

endmodule

[hw/rtl/fir_rh_check.sv]
// Port-level checker for the ring-history FIR filter and its bind to the top level.
module fir_rh_check (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fir_rh_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import fir_rh_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A sample request keeps the block busy in the following cycle.
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_FILTER) |=> !s_axis_tready)
        else $error("request taken while a sum is in progress");

    // Reset empties the result register and starts the clearing sweep.
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_axis_tready)
        else $error("requests taken before the stores are cleared");

    // The padding above the result field stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:ACC_W] == '0))
        else $error("result padding not zero");

endmodule

bind fir_filter_ring_history_unit fir_rh_check u_fir_rh_check (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[sim/fir_filter_ring_history_checker.sv]
// Checker for the ring-history FIR filter: predicts each filtered result and compares it.
`timescale 1ns / 1ps

module fir_filter_ring_history_checker #(
    parameter int MAX_TAPS = fir_rh_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [fir_rh_pkg::TAP_COUNT_W-1:0] cfg_wr_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // Requests: sample[15:0], coef_index[23:16], coef_value[41:24], zeros.
    input  logic [fir_rh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                               s_axis_tuser,   // mode
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Results: filtered[41:0], zeros.
    input  logic [fir_rh_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output int                                 expected_count,
    output int                                 mismatch_count
);
    import fir_rh_pkg::*;

    // Shadow copy of the filter state.
    logic signed [SAMPLE_W-1:0]  sample_ring [MAX_TAPS];
    logic signed [COEF_W-1:0]    coef_bank [MAX_TAPS];
    int                          write_slot;
    logic [TAP_COUNT_W-1:0]      taps_in_use;

    // Filtered results still owed by the block, oldest first.
    logic [ACC_W-1:0]            filtered_q [$];
    int                          error_total;

    initial begin
        expected_count = 0;
        mismatch_count = 0;
        error_total    = 0;
    end

    // Dot product of the newest samples with the coefficients; coefficient 0
    // meets the oldest sample of the window.
    function automatic logic [ACC_W-1:0] filter_output();
        int                 n;
        int                 base;
        int                 k;
        logic signed [63:0] acc;
        n = (int'(taps_in_use) > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
        base = (write_slot + MAX_TAPS - n) % MAX_TAPS;
        acc = '0;
        for (k = 0; k < n; k++) begin
            acc += coef_bank[k] * sample_ring[(base + k) % MAX_TAPS];
        end
        return acc[ACC_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [ACC_W-1:0]  want;
        logic [IDX_W-1:0]  slot;
        if (!aresetn) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                sample_ring[i] = '0;
                coef_bank[i]   = '0;
            end
            write_slot  = 0;
            taps_in_use = TAP_COUNT_RESET;
            filtered_q.delete();
        end else begin
            if (cfg_wr_en) begin
                taps_in_use = cfg_wr_data;
            end

            // Results are checked before this edge's request is modeled, since
            // a request can never produce its result at the edge it is taken.
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_q.size() == 0) begin
                    if (error_total < 10) begin
                        $display("[%0t] unexpected result: filtered %0d", $realtime,
                                 $signed(m_axis_tdata[ACC_W-1:0]));
                    end
                    error_total++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_axis_tdata[ACC_W-1:0] !== want ||
                        m_axis_tdata[M_TDATA_W-1:ACC_W] !== '0) begin
                        if (error_total < 10) begin
                            $display("[%0t] filtered: expected %0d, actual %0d (pad %h)",
                                     $realtime, $signed(want),
                                     $signed(m_axis_tdata[ACC_W-1:0]),
                                     m_axis_tdata[M_TDATA_W-1:ACC_W]);
                        end
                        error_total++;
                    end
                end
            end

            // Model the request taken at this edge.
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == MODE_COEF) begin
                    slot = s_axis_tdata[SAMPLE_W +: IDX_W];
                    if (int'(slot) < MAX_TAPS) begin
                        coef_bank[slot] = s_axis_tdata[SAMPLE_W + IDX_W +: COEF_W];
                    end
                end else begin
                    sample_ring[write_slot] = s_axis_tdata[SAMPLE_W-1:0];
                    write_slot = (write_slot + 1) % MAX_TAPS;
                    filtered_q.push_back(filter_output());
                end
            end
        end
        expected_count <= filtered_q.size();
        mismatch_count <= error_total;
    end

endmodule

[sim/fir_filter_ring_history_unit_test.sv]
// Testbench top for the ring-history FIR filter: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module fir_filter_ring_history_unit_test;
    import fir_rh_pkg::*;

    localparam int TAP_DEPTH      = MAX_TAPS_DEFAULT;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = TAP_DEPTH + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PERCENT   = 22;
    localparam int PHASE_COUNT    = 13;
    localparam int CALM_PHASE     = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};

    // Tap counts of the random phases, including zero and values above the depth.
    localparam int PHASE_TAPS [PHASE_COUNT] = '{1, 2, 8, 256, 0, 17, 511, 33, 3, 300,
                                                100, 5, 64};

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [TAP_COUNT_W-1:0] cfg_wr_data   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = MODE_FILTER;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   calm          = 1'b0;
    int                     expected_count;
    int                     mismatch_count;
    int                     quiet_cycles  = 0;

    fir_filter_ring_history_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fir_filter_ring_history_checker #(.MAX_TAPS(TAP_DEPTH)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .expected_count (expected_count),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The result side stalls at random except during the calm stretch.
    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // End the run when nothing has moved for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with random gaps ahead of it, and wait until it is taken.
    // The valid stays high afterwards so back-to-back requests need no gap.
    task automatic push_request(input logic mode, input logic [41:0] fields);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(S_TDATA_W-42){1'b0}}, fields};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Sample request; the coefficient fields carry noise.
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        push_request(MODE_FILTER, {COEF_W'($urandom), IDX_W'($urandom), value});
    endtask

    // Coefficient request; the sample field carries noise.
    task automatic push_coef(input logic [IDX_W-1:0] slot, input logic [COEF_W-1:0] value);
        push_request(MODE_COEF, {value, slot, SAMPLE_W'($urandom)});
    endtask

    // Drain all owed results, let the block settle, then write the tap count.
    task automatic set_tap_count(input int value);
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= TAP_COUNT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int               live;
        int               items;
        logic [IDX_W-1:0] slot;
        logic [COEF_W-1:0] coef;
        logic [SAMPLE_W-1:0] sample;

        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset tap count. The stores are clear, so the
        // first result is zero, and early windows read zero history.
        push_sample(SAMPLE_MAX);
        push_coef(8'd0, COEF_MAX);
        push_coef(8'd64, COEF_MIN);
        push_coef(8'd255, COEF_MIN);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample('0);
        push_coef(8'd1, '1);
        push_sample('1);

        // An empty sum gives zero.
        set_tap_count(0);
        push_sample(16'h1234);

        // A tap count beyond the depth is capped at the depth.
        set_tap_count(511);
        push_sample(SAMPLE_MIN);
        push_coef(8'd255, COEF_MAX);
        push_sample(SAMPLE_MAX);

        set_tap_count(TAP_DEPTH);
        push_sample(SAMPLE_MIN);

        set_tap_count(1);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);

        // Random phases, each at its own tap count; the long ones stay short.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_tap_count(PHASE_TAPS[p]);
            calm <= (p == CALM_PHASE);
            live = (PHASE_TAPS[p] > TAP_DEPTH) ? TAP_DEPTH : PHASE_TAPS[p];
            items = (PHASE_TAPS[p] >= 128) ? 80 : 180;
            for (int i = 0; i < items; i++) begin
                if ($urandom_range(99) < 30) begin
                    // Mostly aim coefficient writes at slots inside the window.
                    if (live > 0 && $urandom_range(3) != 0) begin
                        slot = IDX_W'($urandom_range(live - 1));
                    end else begin
                        slot = IDX_W'($urandom);
                    end
                    case ($urandom_range(7))
                        0:       coef = COEF_MIN;
                        1:       coef = COEF_MAX;
                        default: coef = COEF_W'($urandom);
                    endcase
                    push_coef(slot, coef);
                end else begin
                    case ($urandom_range(7))
                        0:       sample = SAMPLE_MIN;
                        1:       sample = SAMPLE_MAX;
                        default: sample = SAMPLE_W'($urandom);
                    endcase
                    push_sample(sample);
                end
            end
            calm <= 1'b0;
        end

        // Wait for every owed result, then a little longer for strays.
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_count != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/fir_rh_pkg.sv
hw/rtl/fir_rh_mac.sv
hw/rtl/fir_filter_ring_history_unit.sv
hw/rtl/fir_rh_check.sv
sim/fir_filter_ring_history_checker.sv
sim/fir_filter_ring_history_unit_test.sv
